### hw/rtl/wnc_pkg.sv
// Shared types and constants for the wall neighbor code block.
`default_nettype none
package wnc_pkg;
	// Fixed field widths.
	localparam int ROW_W  = 32;
	localparam int X_W    = 5;
	localparam int CODE_W = 4;
	localparam int CFG_W  = 6;

	// One input request: a row of wall flags.
	typedef struct packed {
		logic [ROW_W-1:0] row_walls;
		logic             last_row;
	} wnc_in_t;

	// One result: the code of a single cell.
	typedef struct packed {
		logic [X_W-1:0]    cell_x;
		logic              is_wall;
		logic [CODE_W-1:0] neighbor_code;
		logic              grid_done;
		logic              run_last;
	} wnc_out_t;

	// Work handed from the sequencer to the cell unit, one cell per request.
	typedef struct packed {
		logic [ROW_W-1:0] mid;
		logic [ROW_W-1:0] up;
		logic [ROW_W-1:0] down;
		logic [X_W-1:0]   x;
		logic             at_end;
		logic             final_row;
		logic             run_last;
	} wnc_req_t;
endpackage
`default_nettype wire

### hw/rtl/wnc_cell_unit.sv
// Shared cell unit: computes one cell's neighbor code and holds it in the output register.
`default_nettype none
module wnc_cell_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	input  wire wnc_pkg::wnc_req_t req,
	output logic                   req_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output wnc_pkg::wnc_out_t      out_data
);
	import wnc_pkg::*;

	logic [ROW_W:0] right_vec;
	logic [ROW_W:0] left_vec;
	logic [X_W:0]   x_ext;
	logic [X_W:0]   x_next;
	logic           wall;
	logic           bit_r;
	logic           bit_u;
	logic           bit_l;
	logic           bit_d;
	logic           out_valid_q;
	wnc_out_t       out_q;
	wnc_out_t       cell_res;

	// Neighbor bits of the selected cell; the right neighbor stops at the row end.
	always_comb begin
		right_vec = {1'b0, req.mid};
		left_vec  = {req.mid, 1'b0};
		x_ext     = {1'b0, req.x};
		x_next    = x_ext + 1'b1;
		wall      = req.mid[req.x];
		bit_r     = right_vec[x_next] & ~req.at_end;
		bit_u     = req.up[req.x];
		bit_l     = left_vec[x_ext];
		bit_d     = req.down[req.x];
		cell_res.cell_x        = req.x;
		cell_res.is_wall       = wall;
		cell_res.neighbor_code = wall ? {bit_d, bit_l, bit_u, bit_r} : '0;
		cell_res.grid_done     = req.final_row & req.at_end;
		cell_res.run_last      = req.run_last & req.at_end;
	end

	// The output register frees up when its result is taken.
	assign req_ready = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req_ready) begin
			out_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			out_q <= cell_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

### hw/rtl/wnc_seq.sv
// Row sequencer: holds the row window and steps the cell unit across each row.
`default_nettype none
module wnc_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire wnc_pkg::wnc_in_t  in_data,
	input  wire logic [4:0]        last_x,
	output logic                   req_valid,
	output wnc_pkg::wnc_req_t      req,
	input  wire logic              req_ready
);
	import wnc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic             state_q;
	logic [ROW_W-1:0] mid_q;
	logic [ROW_W-1:0] low_q;
	logic             mid_valid_q;
	logic [ROW_W-1:0] cur_mid_q;
	logic [ROW_W-1:0] cur_up_q;
	logic [ROW_W-1:0] cur_down_q;
	logic [ROW_W-1:0] pend_q;
	logic             pend_valid_q;
	logic [X_W-1:0]   x_q;
	logic             final_q;
	logic             runl_q;
	logic             in_take;
	logic             req_take;
	logic             at_end;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_take   = in_valid & in_ready;
	assign req_valid = (state_q == ST_EMIT);
	assign req_take  = req_valid & req_ready;
	assign at_end    = (x_q == last_x[X_W-1:0]);

	always_comb begin
		req.mid       = cur_mid_q;
		req.up        = cur_up_q;
		req.down      = cur_down_q;
		req.x         = x_q;
		req.at_end    = at_end;
		req.final_row = final_q;
		req.run_last  = runl_q;
	end

	// Control: idle until a request with a row to emit arrives, then one cell per accepted step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mid_q        <= '0;
			low_q        <= '0;
			mid_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
			x_q          <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						x_q <= '0;
						if (mid_valid_q) begin
							state_q      <= ST_EMIT;
							pend_valid_q <= in_data.last_row;
						end else if (in_data.last_row) begin
							state_q      <= ST_EMIT;
							pend_valid_q <= 1'b0;
						end
						// Row window update; a last row ends the grid.
						if (in_data.last_row) begin
							mid_q       <= '0;
							low_q       <= '0;
							mid_valid_q <= 1'b0;
						end else begin
							if (mid_valid_q) begin
								low_q <= mid_q;
							end
							mid_q       <= in_data.row_walls;
							mid_valid_q <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (req_take) begin
						if (!at_end) begin
							x_q <= x_q + 1'b1;
						end else if (pend_valid_q) begin
							x_q          <= '0;
							pend_valid_q <= 1'b0;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Row currently being emitted and its neighbors.
	always_ff @(posedge clk) begin
		if (in_take) begin
			pend_q <= in_data.row_walls;
			if (mid_valid_q) begin
				cur_mid_q  <= mid_q;
				cur_up_q   <= in_data.row_walls;
				cur_down_q <= low_q;
				final_q    <= 1'b0;
				runl_q     <= ~in_data.last_row;
			end else begin
				cur_mid_q  <= in_data.row_walls;
				cur_up_q   <= '0;
				cur_down_q <= low_q;
				final_q    <= 1'b1;
				runl_q     <= 1'b1;
			end
		end else if (req_take && at_end && pend_valid_q) begin
			cur_mid_q  <= pend_q;
			cur_up_q   <= '0;
			cur_down_q <= cur_mid_q;
			final_q    <= 1'b1;
			runl_q     <= 1'b1;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/wall_neighbor_code_rows_core.sv
// Top level of the wall neighbor code block.
//
//   channel | signals                       | carries
//   --------+-------------------------------+---------------------------------
//   input   | in_valid, in_ready, in_data   | one grid row per request
//   output  | out_valid, out_ready, out_data| one cell code per request
//   config  | cfg_we, cfg_wdata             | row_width, no wait, no read-back
//
// A row request is taken and then produces zero, one or two rows of results, each as
// many cells as the clamped row width, at one cell per cycle while the output is not
// stalled, with the sequencer stepping the shared cell unit.
// in_ready is low while the sequencer emits; a stalled output holds the sequencer.
// Reset clears the stored rows and sets row_width to 32; no clearing pass is needed.
`default_nettype none
module wall_neighbor_code_rows_core #(
	parameter int MAX_ROW_CELLS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire wnc_pkg::wnc_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output wnc_pkg::wnc_out_t      out_data,
	input  wire logic              cfg_we,
	input  wire logic [5:0]        cfg_wdata
);
	import wnc_pkg::*;

	localparam logic [CFG_W-1:0] MAX_W = CFG_W'(MAX_ROW_CELLS);

	logic [CFG_W-1:0] row_width_q;
	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] w_m1;
	logic             req_valid;
	logic             req_ready;
	wnc_req_t         req;

	// Row width register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= CFG_W'(32);
		end else if (cfg_we) begin
			row_width_q <= cfg_wdata;
		end
	end

	// Clamp the width to the supported range.
	always_comb begin
		if (row_width_q == '0) begin
			w_eff = CFG_W'(1);
		end else if (row_width_q > MAX_W) begin
			w_eff = MAX_W;
		end else begin
			w_eff = row_width_q;
		end
		w_m1 = w_eff - CFG_W'(1);
	end

	wnc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.last_x    (w_m1[X_W-1:0]),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready)
	);

	wnc_cell_unit u_cell (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);
endmodule
`default_nettype wire

### hw/rtl/wnc_checker.sv
// Port-level checks for the wall neighbor code block, bound to the top level.
`default_nettype none
module wnc_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire wnc_pkg::wnc_in_t  in_data,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire wnc_pkg::wnc_out_t out_data
);
	// A last row always produces results, so the block must go busy.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_data.last_row |=> !in_ready)
		else $error("block stayed ready after a last row");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	// The end of the grid is also the end of its request's results.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.grid_done |-> out_data.run_last)
		else $error("grid_done without run_last");

	// A non-wall cell carries no code.
	a_nonwall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.is_wall |-> out_data.neighbor_code == 4'd0)
		else $error("non-wall cell with a code");
endmodule

bind wall_neighbor_code_rows_core wnc_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire

### verif/tb_wall_neighbor_code_rows_core.sv
// Self-checking testbench for wall_neighbor_code_rows_core with a built-in code predictor.
`timescale 1ns / 100ps
module tb_wall_neighbor_code_rows_core;
	import wnc_pkg::*;

	localparam int          ROW_REQUESTS = 250;
	localparam int          SETTLE       = 8;
	localparam int          TAIL         = 40;
	localparam int          LONG_HOLD    = 300;
	localparam int unsigned STALL_LIMIT  = 5000;

	typedef enum bit {STEP_ROW, STEP_WIDTH} step_kind_e;

	// One line of the directed plan; the hand fields give the first cell code where it is obvious.
	typedef struct {
		step_kind_e kind;
		bit [31:0]  value;
		bit         last;
		bit         hand_ok;
		bit [4:0]   hx;
		bit         hw;
		bit [3:0]   hc;
		bit         hd;
		bit         hr;
	} plan_step_t;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	wnc_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	wnc_out_t out_data;
	logic     cfg_we;
	logic [5:0] cfg_wdata;

	// Predictor state: a copy of the width register and the two held rows.
	bit [5:0]  width_reg;
	bit [31:0] held_mid;
	bit [31:0] held_low;
	bit        mid_ok;
	bit        low_ok;
	wnc_out_t  expected_cells[$];

	int          errors;
	int          hold_ask;
	bit          calm;
	int unsigned quiet_cycles;

	plan_step_t plan [0:24] = '{
		'{STEP_ROW,   32'h0000_0000, 1'b1, 1'b1, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'hFFFF_FFFF, 1'b1, 1'b1, 5'd0, 1'b1, 4'd1, 1'b0, 1'b0},
		'{STEP_ROW,   32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'hFFFF_FFFF, 1'b0, 1'b1, 5'd0, 1'b1, 4'd3, 1'b0, 1'b0},
		'{STEP_ROW,   32'hAAAA_AAAA, 1'b1, 1'b1, 5'd0, 1'b1, 4'd9, 1'b0, 1'b0},
		'{STEP_WIDTH, 32'd0,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'h0000_0001, 1'b1, 1'b1, 5'd0, 1'b1, 4'd0, 1'b1, 1'b1},
		'{STEP_ROW,   32'hFFFF_FFFE, 1'b1, 1'b1, 5'd0, 1'b0, 4'd0, 1'b1, 1'b1},
		'{STEP_ROW,   32'h0000_0001, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'h0000_0001, 1'b1, 1'b1, 5'd0, 1'b1, 4'd2, 1'b0, 1'b0},
		'{STEP_WIDTH, 32'd63,        1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'h8000_0000, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'hC000_0000, 1'b0, 1'b1, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'h5555_5555, 1'b1, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_WIDTH, 32'd5,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'h0000_001F, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_WIDTH, 32'd32,        1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'hFFFF_FFFF, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_WIDTH, 32'd3,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'h1234_5678, 1'b1, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_WIDTH, 32'd33,        1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'h5A5A_5A5A, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'hDEAD_BEEF, 1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_ROW,   32'h0000_0001, 1'b1, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0},
		'{STEP_WIDTH, 32'd1,         1'b0, 1'b0, 5'd0, 1'b0, 4'd0, 1'b0, 1'b0}
	};

	wall_neighbor_code_rows_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Free-running clock with a 4 ns period.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// The width in use: zero reads as one cell, anything above the row size as a full row.
	function automatic int unsigned cells_in_use();
		if (width_reg == 6'd0)
			return 1;
		if (width_reg > 6'd32)
			return 32;
		return width_reg;
	endfunction

	// Queue the codes of one row, masked with the width in use right now.
	task automatic queue_row_codes(input bit [31:0] mid, input bit [31:0] up,
		input bit [31:0] down, input bit final_row, input bit run_end);
		int unsigned w;
		bit [63:0]   mask;
		bit [63:0]   m;
		bit [63:0]   u;
		bit [63:0]   d;
		wnc_out_t    c;
		w = cells_in_use();
		mask = (64'd1 << w) - 64'd1;
		m = {32'd0, mid} & mask;
		u = {32'd0, up} & mask;
		d = {32'd0, down} & mask;
		for (int x = 0; x < w; x++) begin
			c.cell_x = x[4:0];
			c.is_wall = m[x];
			c.neighbor_code = '0;
			if (m[x]) begin
				c.neighbor_code = {d[x], (x > 0) ? m[x-1] : 1'b0, u[x], m[x+1]};
			end
			c.grid_done = final_row && (x == w - 1);
			c.run_last = run_end && (x == w - 1);
			expected_cells.push_back(c);
		end
	endtask

	// Advance the row pipeline by one accepted request.
	task automatic predict_row(input bit [31:0] row, input bit last);
		if (mid_ok) begin
			queue_row_codes(held_mid, row, low_ok ? held_low : 32'd0, 1'b0, !last);
			held_low = held_mid;
			low_ok = 1'b1;
		end
		held_mid = row;
		mid_ok = 1'b1;
		if (last) begin
			queue_row_codes(held_mid, 32'd0, low_ok ? held_low : 32'd0, 1'b1, 1'b1);
			held_mid = '0;
			held_low = '0;
			mid_ok = 1'b0;
			low_ok = 1'b0;
		end
	endtask

	// Offer one row, wait for the handshake, then perhaps leave a gap.
	task automatic send_row(input bit [31:0] row, input bit last, input bit hand_ok,
		input wnc_out_t hand);
		int first_idx;
		in_data <= '{row_walls: row, last_row: last};
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		first_idx = expected_cells.size();
		predict_row(row, last);
		// A typed first code replaces the predicted one.
		if (hand_ok)
			expected_cells[first_idx] = hand;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every queued code has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_cells.size() != 0)
			@(posedge clk);
		// A request that makes no codes may still be in flight.
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_width(input bit [5:0] w);
		wait_drained();
		cfg_wdata <= w;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		width_reg = w;
	endtask

	// Rows of varied density so every neighbor pattern turns up.
	function automatic bit [31:0] random_row();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom & $urandom;
			3: return $urandom | $urandom;
			4: return 32'd1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic report(input string field, input int want, input int got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	// Receiver: random stall bursts, stretches of steady ready, and one long hold on request.
	initial begin : result_sink
		int unsigned stall_left;
		int unsigned run_left;
		int          seen;
		stall_left = 0;
		run_left = 0;
		seen = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_ask != seen) begin
				seen = hold_ask;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (run_left > 0 || calm) begin
				out_ready <= 1'b1;
				if (run_left > 0)
					run_left--;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				out_ready <= 1'b0;
			end else begin
				run_left = $urandom_range(0, 40);
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each delivered cell code with the oldest prediction.
	always @(posedge clk) begin : check_results
		wnc_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_cells.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %p", $time, out_data);
			end else begin
				want = expected_cells.pop_front();
				if (out_data.cell_x !== want.cell_x)
					report("cell_x", want.cell_x, out_data.cell_x);
				if (out_data.is_wall !== want.is_wall)
					report("is_wall", want.is_wall, out_data.is_wall);
				if (out_data.neighbor_code !== want.neighbor_code)
					report("neighbor_code", want.neighbor_code, out_data.neighbor_code);
				if (out_data.grid_done !== want.grid_done)
					report("grid_done", want.grid_done, out_data.grid_done);
				if (out_data.run_last !== want.run_last)
					report("run_last", want.run_last, out_data.run_last);
			end
		end
	end

	// Watchdog: too long without any handshake on either channel ends the run.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Main sequence: reset, directed plan, random grids, drain and verdict.
	initial begin : stimulus
		wnc_out_t    hand_cell;
		int          sent;
		int          phase;
		int          height;
		bit [5:0]    width_picks [0:6];
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		errors = 0;
		hold_ask = 0;
		calm = 1'b0;
		quiet_cycles = 0;
		width_reg = 6'd32;
		held_mid = '0;
		held_low = '0;
		mid_ok = 1'b0;
		low_ok = 1'b0;
		width_picks = '{6'd0, 6'd1, 6'd2, 6'd31, 6'd32, 6'd33, 6'd63};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan; typed first codes replace the predicted ones.
		foreach (plan[i]) begin
			if (plan[i].kind == STEP_WIDTH) begin
				write_width(plan[i].value[5:0]);
			end else begin
				hand_cell.cell_x        = plan[i].hx;
				hand_cell.is_wall       = plan[i].hw;
				hand_cell.neighbor_code = plan[i].hc;
				hand_cell.grid_done     = plan[i].hd;
				hand_cell.run_last      = plan[i].hr;
				send_row(plan[i].value, plan[i].last, plan[i].hand_ok, hand_cell);
			end
		end

		// Random grids, a new width per phase, with the extremes first.
		sent = 0;
		phase = 0;
		while (sent < ROW_REQUESTS) begin
			write_width(phase < 7 ? width_picks[phase] : 6'($urandom_range(0, 63)));
			phase++;
			repeat ($urandom_range(2, 4)) begin
				height = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
					: $urandom_range(1, 6);
				for (int r = 0; r < height; r++) begin
					// Now and then retune the width in the middle of a grid.
					if (r > 0 && $urandom_range(0, 15) == 0)
						write_width(6'($urandom_range(0, 63)));
					if (sent == 60)
						hold_ask++;
					if (sent == 120)
						wait_drained();
					if (sent >= ROW_REQUESTS - 40)
						calm = 1'b1;
					// Most grids end with a top row; a few are left open into the next one.
					send_row(random_row(), (r == height - 1) && $urandom_range(0, 7) != 0,
						1'b0, '0);
					sent++;
				end
			end
		end

		wait_drained();
		repeat (TAIL) @(posedge clk);
		if (errors == 0 && expected_cells.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule

### filelist.f
hw/rtl/wnc_pkg.sv
hw/rtl/wnc_cell_unit.sv
hw/rtl/wnc_seq.sv
hw/rtl/wall_neighbor_code_rows_core.sv
hw/rtl/wnc_checker.sv
verif/tb_wall_neighbor_code_rows_core.sv
